FILE: src/mam_pkg.sv
// shared types and constants for the multichannel audio mixer
`timescale 1ns / 1ps
package mam_pkg;

    localparam logic [2:0] OP_SET_VOLUME = 3'd0;
    localparam logic [2:0] OP_SET_PAN    = 3'd1;
    localparam logic [2:0] OP_SET_FADE   = 3'd2;
    localparam logic [2:0] OP_START      = 3'd3;
    localparam logic [2:0] OP_STOP       = 3'd4;
    localparam logic [2:0] OP_RESET      = 3'd5;
    localparam logic [2:0] OP_BLOCK      = 3'd6;
    localparam logic [2:0] OP_SAMPLE     = 3'd7;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    localparam logic [30:0] VOLUME_CEIL = 31'd2147418112;
    localparam logic [30:0] UNITY_GAIN  = 31'd16777216;
    localparam logic [8:0]  PAN_FULL    = 9'd256;
    localparam logic [8:0]  PAN_CENTRE  = 9'd128;
    localparam logic [10:0] BLOCK_MAX   = 11'd1024;
    localparam logic [10:0] BLOCK_MIN   = 11'd1;
    localparam logic [3:0]  EVENT_CAP   = 4'd8;

    typedef struct packed {
        logic [2:0]         operation;
        logic [2:0]         voice;
        logic [30:0]        value;
        logic signed [31:0] rate;
        logic               flag;
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
        logic               frame_end;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [2:0]         voice_out;
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic mul;
        logic acc;
        logic blk;
        logic fade_a;
        logic fade_b;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic need_ev;
        logic frame_end;
        logic need_out_fade;
        logic pend_valid;
    } dp_status_t;

    function automatic logic [30:0] clamp_level(input logic [30:0] v);
        return (v > VOLUME_CEIL) ? VOLUME_CEIL : v;
    endfunction

    function automatic logic [8:0] clamp_pan(input logic [30:0] v);
        return (v > 31'(PAN_FULL)) ? PAN_FULL : v[8:0];
    endfunction

endpackage

FILE: src/multichannel_audio_mixer.sv
// top level of the multichannel audio mixer
//
//   channel  dir  handshake            beat
//   s_       in   s_valid / s_ready    in_item_t control or sample
//   m_       out  m_valid / m_ready    out_item_t frame or stopped voice
//   cfg_     in   cfg_valid / cfg_ready block_length, always ready
//
// control items are loaded, then executed; sample items are loaded, multiplied, then panned and added
// block begin runs fade stages a and b for each voice, then a flush: one fade unit walks the voices
// reset is synchronous; no clearing pass, voice state resets at once
// a full output register stalls the sequencer only when a new beat is due
`timescale 1ns / 1ps
module multichannel_audio_mixer
    import mam_pkg::*;
#(
    parameter int VOICES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    ctrl_cmd_t     cmd;
    dp_status_t    status;
    logic [VW-1:0] fidx;

    assign cfg_ready = 1'b1;

    mam_ctrl #(.VOICES(VOICES), .VW(VW)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.operation),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd),
        .fidx    (fidx)
    );

    mam_dp #(.VOICES(VOICES), .VW(VW)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cmd       (cmd),
        .fidx      (fidx),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: src/mam_ctrl.sv
// sequencing state machine for the mixer
`timescale 1ns / 1ps
module mam_ctrl
    import mam_pkg::*;
#(
    parameter int VOICES = 8,
    parameter int VW     = 3
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic [2:0]    s_op,
    output logic          s_ready,
    input  dp_status_t    status,
    output ctrl_cmd_t     cmd,
    output logic [VW-1:0] fidx
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_ACC    = 3'd3;
    localparam logic [2:0] ST_FADE_A = 3'd4;
    localparam logic [2:0] ST_FADE_B = 3'd5;
    localparam logic [2:0] ST_FLUSH  = 3'd6;

    localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

    logic [2:0]    state_reg, state_next;
    logic [VW-1:0] cnt_reg, cnt_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign fidx    = cnt_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    case (s_op)
                        OP_BLOCK:  state_next = ST_FADE_A;
                        OP_SAMPLE: state_next = ST_MUL;
                        default:   state_next = ST_EXEC;
                    endcase
                end
            end
            ST_EXEC: begin
                if (!status.need_ev || status.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (!status.frame_end || status.out_free) begin
                    cmd.acc    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FADE_A: begin
                cmd.blk    = 1'b1;
                cmd.fade_a = 1'b1;
                state_next = ST_FADE_B;
            end
            ST_FADE_B: begin
                cmd.blk = 1'b1;
                if (!status.need_out_fade || status.out_free) begin
                    cmd.fade_b = 1'b1;
                    if (cnt_reg == LAST_VOICE) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_FADE_A;
                    end
                end
            end
            ST_FLUSH: begin
                if (!status.pend_valid || status.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: src/mam_dp.sv
// voice state, fade arithmetic, mixing and output register
`timescale 1ns / 1ps
module mam_dp
    import mam_pkg::*;
#(
    parameter int VOICES = 8,
    parameter int VW     = 3
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  in_item_t      s_data,
    input  ctrl_cmd_t     cmd,
    input  logic [VW-1:0] fidx,
    output dp_status_t    status,
    input  logic          cfg_valid,
    input  logic [10:0]   cfg_data,
    output logic          m_valid,
    input  logic          m_ready,
    output out_item_t     m_data
);

    logic               playing_reg [VOICES];
    logic               stereo_reg  [VOICES];
    logic               cut_reg     [VOICES];
    logic [30:0]        vol_reg     [VOICES];
    logic signed [31:0] step_reg    [VOICES];
    logic [30:0]        goal_reg    [VOICES];
    logic [8:0]         pan_reg     [VOICES];

    in_item_t    item_reg;
    logic [10:0] blen_reg;
    logic [15:0] accl_reg, accr_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;
    logic        pend_valid_reg;
    logic [2:0]  pend_voice_reg;
    logic [3:0]  ev_cnt_reg;

    logic [42:0] m_reg;
    logic [31:0] absdiff_reg, abss_reg;
    logic        opp_reg, zero_reg, neg_reg;
    logic signed [31:0] pl_reg, pr_reg;

    logic [6:0]    vx, fx;
    logic          ok;
    logic [VW-1:0] sel, rd;
    logic          ply, ster, cut;
    logic [30:0]   vol, goal;
    logic signed [31:0] step;
    logic [8:0]    pan;

    assign vx  = {4'b0, item_reg.voice};
    assign fx  = 7'(fidx);
    assign ok  = vx < 7'(VOICES);
    assign sel = vx[VW-1:0];
    assign rd  = cmd.blk ? fidx : sel;

    assign ply  = playing_reg[rd];
    assign ster = stereo_reg[rd];
    assign cut  = cut_reg[rd];
    assign vol  = vol_reg[rd];
    assign goal = goal_reg[rd];
    assign step = step_reg[rd];
    assign pan  = pan_reg[rd];

    // fade stage a: magnitudes and the scaled step
    logic signed [32:0] diff, step_x;
    logic [31:0]        absdiff, abss;
    logic [42:0]        prod;

    assign diff    = $signed({2'b0, goal}) - $signed({2'b0, vol});
    assign step_x  = {step[31], step};
    assign absdiff = diff[32] ? 32'(-diff) : diff[31:0];
    assign abss    = step_x[32] ? 32'(-step_x) : step_x[31:0];
    assign prod    = {11'b0, abss} * {32'b0, blen_reg};

    // fade stage b: snap or advance, then cut check
    logic [42:0] thr;
    logic        snap, fading, ev;
    logic [30:0] adv, newvol;

    assign thr    = m_reg + {11'b0, abss_reg};
    assign snap   = opp_reg || zero_reg || ({11'b0, absdiff_reg} < thr);
    assign fading = (step != 32'sd0);
    assign adv    = neg_reg ? (vol - m_reg[30:0]) : (vol + m_reg[30:0]);
    assign newvol = (fading && ply) ? (snap ? goal : adv) : vol;
    assign ev     = ply && (newvol == 31'd0) && cut;

    // mixing
    logic [14:0]        g;
    logic signed [31:0] pl, pr;
    logic [8:0]         pn;
    logic signed [41:0] ml, mr;
    logic [15:0]        dl, dr, suml, sumr;

    assign g  = vol[30:16];
    assign pl = 32'(item_reg.left_in * $signed({1'b0, g}));
    assign pr = 32'(item_reg.right_in * $signed({1'b0, g}));
    assign pn = PAN_FULL - pan;
    assign ml = 42'(pl_reg * $signed({1'b0, pn}));
    assign mr = 42'(pl_reg * $signed({1'b0, pan}));
    assign dl = ster ? pl_reg[25:10] : ml[32:17];
    assign dr = ster ? pr_reg[25:10] : mr[32:17];
    assign suml = (ok && ply) ? accl_reg + dl : accl_reg;
    assign sumr = (ok && ply) ? accr_reg + dr : accr_reg;

    assign status.out_free      = !m_valid_reg || m_ready;
    assign status.need_ev       = ((item_reg.operation == OP_STOP) ||
                                   (item_reg.operation == OP_RESET)) && ok && ply;
    assign status.frame_end     = item_reg.frame_end;
    assign status.need_out_fade = ev && (ev_cnt_reg < EVENT_CAP) && pend_valid_reg;
    assign status.pend_valid    = pend_valid_reg;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // result beat selection
    logic      emit;
    out_item_t emit_data;

    always_comb begin
        emit      = 1'b0;
        emit_data = '0;
        if (cmd.exec && status.need_ev) begin
            emit                = 1'b1;
            emit_data.kind      = KIND_EVENT;
            emit_data.voice_out = item_reg.voice;
            emit_data.last      = 1'b1;
        end else if (cmd.acc && item_reg.frame_end) begin
            emit                = 1'b1;
            emit_data.kind      = KIND_FRAME;
            emit_data.left_out  = suml;
            emit_data.right_out = sumr;
            emit_data.last      = 1'b1;
        end else if (cmd.fade_b && status.need_out_fade) begin
            emit                = 1'b1;
            emit_data.kind      = KIND_EVENT;
            emit_data.voice_out = pend_voice_reg;
        end else if (cmd.flush && pend_valid_reg) begin
            emit                = 1'b1;
            emit_data.kind      = KIND_EVENT;
            emit_data.voice_out = pend_voice_reg;
            emit_data.last      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= emit_data;
        end
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.fade_a) begin
            m_reg       <= prod;
            absdiff_reg <= absdiff;
            abss_reg    <= abss;
            opp_reg     <= (diff != 33'sd0) && (diff[32] != step[31]);
            zero_reg    <= (diff == 33'sd0);
            neg_reg     <= step[31];
        end
        if (cmd.mul) begin
            pl_reg <= pl;
            pr_reg <= pr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blen_reg <= BLOCK_MAX;
        end else if (cfg_valid) begin
            if (cfg_data < BLOCK_MIN) begin
                blen_reg <= BLOCK_MIN;
            end else if (cfg_data > BLOCK_MAX) begin
                blen_reg <= BLOCK_MAX;
            end else begin
                blen_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accl_reg       <= '0;
            accr_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_voice_reg <= '0;
            ev_cnt_reg     <= '0;
        end else begin
            if (cmd.acc) begin
                accl_reg <= item_reg.frame_end ? 16'd0 : suml;
                accr_reg <= item_reg.frame_end ? 16'd0 : sumr;
            end
            if (cmd.load) begin
                pend_valid_reg <= 1'b0;
                ev_cnt_reg     <= '0;
            end
            if (cmd.fade_b && ev && (ev_cnt_reg < EVENT_CAP)) begin
                pend_valid_reg <= 1'b1;
                pend_voice_reg <= fx[2:0];
                ev_cnt_reg     <= ev_cnt_reg + 1'b1;
            end
            if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int v = 0; v < VOICES; v++) begin
                playing_reg[v] <= 1'b0;
                stereo_reg[v]  <= 1'b0;
                cut_reg[v]     <= 1'b0;
                vol_reg[v]     <= UNITY_GAIN;
                step_reg[v]    <= '0;
                goal_reg[v]    <= '0;
                pan_reg[v]     <= PAN_CENTRE;
            end
        end else if (cmd.exec && ok) begin
            case (item_reg.operation)
                OP_SET_VOLUME: begin
                    vol_reg[sel]  <= clamp_level(item_reg.value);
                    step_reg[sel] <= '0;
                    cut_reg[sel]  <= 1'b0;
                end
                OP_SET_PAN: begin
                    pan_reg[sel] <= clamp_pan(item_reg.value);
                end
                OP_SET_FADE: begin
                    if (item_reg.rate == 32'sd0) begin
                        step_reg[sel] <= '0;
                        cut_reg[sel]  <= 1'b0;
                    end else begin
                        step_reg[sel] <= item_reg.rate;
                        goal_reg[sel] <= clamp_level(item_reg.value);
                        cut_reg[sel]  <= item_reg.flag;
                    end
                end
                OP_START: begin
                    playing_reg[sel] <= 1'b1;
                    stereo_reg[sel]  <= item_reg.flag;
                end
                OP_STOP: begin
                    playing_reg[sel] <= 1'b0;
                end
                OP_RESET: begin
                    playing_reg[sel] <= 1'b0;
                    stereo_reg[sel]  <= 1'b0;
                    cut_reg[sel]     <= 1'b0;
                    vol_reg[sel]     <= UNITY_GAIN;
                    step_reg[sel]    <= '0;
                    pan_reg[sel]     <= PAN_CENTRE;
                end
                default: begin
                end
            endcase
        end else if (cmd.fade_b && ply) begin
            vol_reg[rd] <= newvol;
            if (fading && snap) begin
                step_reg[rd] <= '0;
            end
            if (ev) begin
                playing_reg[rd] <= 1'b0;
            end
        end
    end

endmodule

FILE: src/mam_chk.sv
// port checker for the mixer, bound to the top level
`timescale 1ns / 1ps
module mam_chk
    import mam_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    a_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_FRAME) |-> (m_data.voice_out == 3'd0) && m_data.last)
        else $error("frame beat with voice or without last");

    a_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_EVENT) |->
            (m_data.left_out == 16'sd0) && (m_data.right_out == 16'sd0))
        else $error("event beat with sample data");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

endmodule

bind multichannel_audio_mixer mam_chk u_mam_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: bench/tb_top.sv
// self-checking testbench for the multichannel audio mixer
`timescale 1ns / 1ps
module tb_top;
    import mam_pkg::*;

    localparam int NV = 8;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;

    multichannel_audio_mixer #(.VOICES(NV)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mixer state mirror
    logic              playing [NV];
    logic              stereo [NV];
    logic              cut_on [NV];
    logic [30:0]       volume [NV];
    logic signed [31:0] step [NV];
    logic [30:0]       goal [NV];
    logic [8:0]        pan [NV];
    logic [15:0]       acc_l, acc_r;
    logic [10:0]       blk_len;

    out_item_t expected_beats[$];
    int        errors = 0;
    int        frames_seen = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void voice_defaults(input int v);
        playing[v] = 0; stereo[v] = 0; cut_on[v] = 0;
        volume[v] = UNITY_GAIN; step[v] = 0; pan[v] = PAN_CENTRE;
    endfunction

    function automatic void mirror_reset();
        for (int v = 0; v < NV; v++) begin
            voice_defaults(v);
            goal[v] = 0;
        end
        acc_l = 0; acc_r = 0; blk_len = BLOCK_MAX;
    endfunction

    function automatic void push_beat(input logic k, input logic [2:0] vc,
                                      input logic [15:0] l, input logic [15:0] r);
        out_item_t o;
        o.kind = k; o.voice_out = vc; o.left_out = l; o.right_out = r; o.last = 1'b0;
        expected_beats.push_back(o);
    endfunction

    function automatic void predict_mix(input in_item_t it);
        int n;
        int vc;
        longint diff, remain, nv, g, l, r, dl, dr;
        n = 0;
        vc = it.voice;
        case (it.operation)
            OP_SET_VOLUME: begin
                volume[vc] = clamp_level(it.value); step[vc] = 0; cut_on[vc] = 0;
            end
            OP_SET_PAN: pan[vc] = (it.value > 31'(PAN_FULL)) ? PAN_FULL : it.value[8:0];
            OP_SET_FADE: begin
                if (it.rate == 0) begin
                    step[vc] = 0; cut_on[vc] = 0;
                end else begin
                    step[vc] = it.rate; goal[vc] = clamp_level(it.value);
                    cut_on[vc] = it.flag;
                end
            end
            OP_START: begin
                playing[vc] = 1; stereo[vc] = it.flag;
            end
            OP_STOP, OP_RESET: begin
                if (playing[vc]) begin
                    playing[vc] = 0;
                    push_beat(KIND_EVENT, 3'(vc), 0, 0); n++;
                end
                if (it.operation == OP_RESET) voice_defaults(vc);
            end
            OP_BLOCK: begin
                for (int v = 0; v < NV; v++) begin
                    if (!playing[v]) continue;
                    if (step[v] != 0) begin
                        diff = longint'(goal[v]) - longint'(volume[v]);
                        remain = diff / longint'(step[v]);
                        if (remain < 0 || longint'(blk_len) >= remain) begin
                            volume[v] = goal[v]; step[v] = 0;
                        end else begin
                            nv = longint'(volume[v]) + longint'(step[v]) * longint'(blk_len);
                            if (nv < 0) nv = 0;
                            volume[v] = clamp_level(nv[30:0]);
                        end
                    end
                    if (volume[v] == 0 && cut_on[v]) begin
                        playing[v] = 0;
                        if (n < 8) begin
                            push_beat(KIND_EVENT, 3'(v), 0, 0); n++;
                        end
                    end
                end
            end
            default: begin
                if (playing[vc]) begin
                    g = longint'(volume[vc] >> 16);
                    l = longint'(it.left_in);
                    r = longint'(it.right_in);
                    if (stereo[vc]) begin
                        dl = (l * g) >>> 10;
                        dr = (r * g) >>> 10;
                    end else begin
                        dl = (l * g * (256 - longint'(pan[vc]))) >>> 17;
                        dr = (l * g * longint'(pan[vc])) >>> 17;
                    end
                    acc_l = acc_l + dl[15:0];
                    acc_r = acc_r + dr[15:0];
                end
                if (it.frame_end) begin
                    push_beat(KIND_FRAME, 0, acc_l, acc_r); n++;
                    acc_l = 0; acc_r = 0;
                end
            end
        endcase
        if (n > 0) expected_beats[$].last = 1'b1;
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_mix(it);
    endtask

    task automatic send(input logic [2:0] op, input logic [2:0] vc, input logic [30:0] val,
                        input logic [31:0] rt, input logic fl, input logic [15:0] li,
                        input logic [15:0] ri, input logic fe);
        in_item_t it;
        it.operation = op; it.voice = vc; it.value = val; it.rate = rt; it.flag = fl;
        it.left_in = li; it.right_in = ri; it.frame_end = fe;
        send_item(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_block_length(input logic [10:0] d);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        blk_len = (d < BLOCK_MIN) ? BLOCK_MIN : (d > BLOCK_MAX) ? BLOCK_MAX : d;
    endtask

    // result checker with random receive stalls
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                report("unexpected beat", m_data, 0);
            end else begin
                want = expected_beats.pop_front();
                if (m_data.kind != want.kind) report("kind", m_data.kind, want.kind);
                if (m_data.voice_out != want.voice_out)
                    report("voice_out", m_data.voice_out, want.voice_out);
                if (m_data.left_out != want.left_out)
                    report("left_out", m_data.left_out, want.left_out);
                if (m_data.right_out != want.right_out)
                    report("right_out", m_data.right_out, want.right_out);
                if (m_data.last != want.last) report("last", m_data.last, want.last);
                if (want.kind == KIND_FRAME) frames_seen++;
            end
        end
    end

    int stall_left = 0;
    logic quiet_sink = 1'b0;
    always @(posedge aclk) begin
        if (quiet_sink) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            stall_left <= $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic test_directed();
        send(OP_SAMPLE, 0, 0, 0, 0, 16'h7fff, 0, 1);
        send(OP_START, 0, 0, 0, 0, 0, 0, 0);
        send(OP_START, 1, 0, 0, 1, 0, 0, 0);
        send(OP_SET_VOLUME, 0, 31'h7fffffff, 0, 0, 0, 0, 0);
        send(OP_SET_PAN, 0, 31'h7fffffff, 0, 0, 0, 0, 0);
        send(OP_SAMPLE, 0, 0, 0, 0, 16'h8000, 16'h7fff, 0);
        send(OP_SAMPLE, 1, 0, 0, 0, 16'h7fff, 16'h8000, 1);
        send(OP_SET_PAN, 0, 0, 0, 0, 0, 0, 0);
        send(OP_SAMPLE, 0, 0, 0, 0, 16'h7fff, 0, 1);
        send(OP_SET_FADE, 0, 0, 32'h8000_0000, 1, 0, 0, 0);
        send(OP_SET_FADE, 1, 31'h7fffffff, 32'h7fff_ffff, 0, 0, 0, 0);
        send(OP_SET_FADE, 1, 0, 0, 1, 0, 0, 0);
        send(OP_BLOCK, 0, 0, 0, 0, 0, 0, 0);
        send(OP_SET_FADE, 1, 0, -32'sd1, 1, 0, 0, 0);
        send(OP_BLOCK, 0, 0, 0, 0, 0, 0, 0);
        send(OP_STOP, 2, 0, 0, 0, 0, 0, 0);
        send(OP_STOP, 1, 0, 0, 0, 0, 0, 0);
        send(OP_START, 3, 0, 0, 0, 0, 0, 0);
        send(OP_RESET, 3, 0, 0, 0, 0, 0, 0);
        send(OP_RESET, 3, 0, 0, 0, 0, 0, 0);
        // all voices cut at once
        for (int v = 0; v < NV; v++) begin
            send(OP_START, 3'(v), 0, 0, 0, 0, 0, 0);
            send(OP_SET_FADE, 3'(v), 0, -32'sd65536, 1, 0, 0, 0);
        end
        send(OP_BLOCK, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_config();
        write_block_length(0);
        send(OP_START, 2, 0, 0, 0, 0, 0, 0);
        send(OP_SET_FADE, 2, 0, -32'sd4096, 1, 0, 0, 0);
        send(OP_BLOCK, 0, 0, 0, 0, 0, 0, 0);
        write_block_length(11'h7ff);
        send(OP_BLOCK, 0, 0, 0, 0, 0, 0, 0);
        write_block_length(1);
    endtask

    task automatic random_item();
        in_item_t it;
        int pick;
        it = '0;
        it.voice = 3'($urandom_range(0, 7));
        it.value = 31'($urandom());
        it.rate = $urandom();
        it.flag = 1'($urandom_range(0, 1));
        it.left_in = 16'($urandom());
        it.right_in = 16'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            it.operation = OP_SAMPLE;
            it.frame_end = ($urandom_range(0, 3) == 0);
        end else if (pick < 55) begin
            it.operation = OP_START;
        end else if (pick < 63) begin
            it.operation = OP_SET_VOLUME;
            if ($urandom_range(0, 1)) it.value = 31'($urandom_range(0, 31'h01ffffff));
        end else if (pick < 70) begin
            it.operation = OP_SET_PAN;
            if ($urandom_range(0, 2) != 0) it.value = 31'($urandom_range(0, 256));
        end else if (pick < 80) begin
            it.operation = OP_SET_FADE;
            case ($urandom_range(0, 3))
                0: it.rate = 0;
                1: it.rate = -$signed(32'($urandom_range(1, 70000)));
                2: begin
                    it.rate = $urandom_range(1, 70000);
                    it.value = 31'($urandom_range(0, 31'h02000000));
                end
                default: ;
            endcase
            if ($urandom_range(0, 1)) it.value = 0;
        end else if (pick < 88) begin
            it.operation = OP_BLOCK;
        end else if (pick < 94) begin
            it.operation = OP_STOP;
        end else begin
            it.operation = OP_RESET;
        end
        send_item(it);
    endtask

    task automatic test_random();
        for (int i = 0; i < 270; i++) begin
            if (i == 100) write_block_length(11'd37);
            if (i == 200) write_block_length(BLOCK_MAX);
            if (i == 150) drain();
            random_item();
        end
    endtask

    initial begin
        mirror_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config();
        test_random();
        quiet_sink = 1'b1;
        drain();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
src/mam_pkg.sv
src/mam_ctrl.sv
src/mam_dp.sv
src/multichannel_audio_mixer.sv
src/mam_chk.sv
bench/tb_top.sv
